// ===== hdl/pcbpd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and codes for the per-class bounded priority deque.
// Used by pcbpd_cell and per_class_bounded_priority_deque; depends on nothing.
package pcbpd_pkg;

   // sizes
   localparam int NUM_CLASSES = 20;
   localparam int QUEUE_DEPTH = 5;
   localparam int ID_WIDTH    = 16;

   localparam int MODE_W     = 2;
   localparam int CLASS_W    = 5;
   localparam int STATUS_W   = 2;
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int POS_W      = CNT_W;
   localparam int CLS_ADDR_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TAKE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LIST = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_LISTED = 2'd3;

   // write-value select of one cell
   typedef logic [1:0] pick_type;
   localparam pick_type PICK_OWN   = 2'd0;
   localparam pick_type PICK_LEFT  = 2'd1;
   localparam pick_type PICK_RIGHT = 2'd2;
   localparam pick_type PICK_NEW   = 2'd3;

   // one stored entry
   typedef struct packed {
      logic [ID_WIDTH-1:0] id;
      logic                urg;
   } entry_type;

   // control shared by all cells of the row
   typedef struct packed {
      logic                  load;
      logic                  shift;
      logic                  we;
      logic [CLS_ADDR_W-1:0] addr;
   } cell_ctl_type;

endpackage

// ===== hdl/per_class_bounded_priority_deque.sv =====
`timescale 1ns / 1ps
// Top level of the per-class bounded priority deque: sequencer, length table and
// the row of pcbpd_cell slots. Depends on pcbpd_pkg and pcbpd_cell.
//
// Usage:
//   Requests enter on req_* and are taken at a clock edge with start high and
//   busy low. Results leave on rsp_* for exactly one cycle each, marked by
//   rsp_valid; rsp_last marks the final result of a request. The receiver
//   cannot stall, so results are never held back.
//   Timing: an accepted request reads its class row from the cells in the
//   accept cycle and executes in the next one. Add and take give their single
//   result in the cycle after execution; busy is high for one cycle, so a new
//   request can be taken only after the current one has executed. A list
//   request shifts the row toward slot 0 once per cycle and gives one result
//   per cycle, one per entry; busy stays high until the last of them.
//   Requests with an unused mode or a class out of range are taken and
//   dropped with no result and busy stays low.
//   Reset (synchronous, active high) empties every class; the slot memories
//   themselves are not cleared, since only written slots ever reach a result.
module per_class_bounded_priority_deque (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [pcbpd_pkg::MODE_W-1:0]    req_mode,
   input  logic [pcbpd_pkg::CLASS_W-1:0]   req_class_index,
   input  logic [pcbpd_pkg::ID_WIDTH-1:0]  req_entry_id,
   input  logic                            req_urgent,
   output logic                            rsp_valid,
   output logic [pcbpd_pkg::STATUS_W-1:0]  rsp_result_status,
   output logic [pcbpd_pkg::ID_WIDTH-1:0]  rsp_out_id,
   output logic                            rsp_out_urgent,
   output logic [pcbpd_pkg::POS_W-1:0]     rsp_out_position,
   output logic [pcbpd_pkg::CNT_W-1:0]     rsp_queue_count,
   output logic                            rsp_last
);
   import pcbpd_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic                  state_ff, state_in;
   logic [MODE_W-1:0]     mode_ff;
   logic [CLS_ADDR_W-1:0] cls_ff;
   entry_type             new_ff;
   logic [CNT_W-1:0]      len_ff;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      length_ff [NUM_CLASSES];

   logic                  accept, in_range, mode_ok, go;
   logic [CLS_ADDR_W-1:0] req_addr;
   logic                  full, empty, list_last;

   logic                  len_we;
   logic [CNT_W-1:0]      len_wr;

   logic                  rsp_valid_in;
   logic [STATUS_W-1:0]   status_in;
   entry_type             rsp_entry_in;
   logic [CNT_W-1:0]      count_in;
   logic                  last_in;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   status_ff;
   entry_type             rsp_entry_ff;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [CNT_W-1:0]      count_ff;
   logic                  last_ff;

   cell_ctl_type          ctl;
   pick_type              pick     [QUEUE_DEPTH];
   entry_type             cell_data[QUEUE_DEPTH];
   entry_type             row_head;
   logic                  pick_left, pick_right, pick_tail;

   // decode the request
   assign busy     = (state_ff == S_EXEC);
   assign accept   = start && !busy;
   assign in_range = int'(req_class_index) < NUM_CLASSES;
   assign mode_ok  = (req_mode == MODE_ADD) || (req_mode == MODE_TAKE) ||
                     (req_mode == MODE_LIST);
   assign go       = accept && in_range && mode_ok;
   assign req_addr = CLS_ADDR_W'(req_class_index);

   assign full      = (len_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (len_ff == '0);
   assign list_last = ((pos_ff + POS_W'(1)) == len_ff);
   assign row_head  = cell_data[0];

   // sequence one request: execute, update length, form the result
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      len_we       = 1'b0;
      len_wr       = len_ff;
      rsp_valid_in = 1'b0;
      status_in    = ST_OK;
      rsp_entry_in = '0;
      rsp_pos_in   = '0;
      count_in     = len_ff;
      last_in      = 1'b1;
      pick_left    = 1'b0;
      pick_right   = 1'b0;
      pick_tail    = 1'b0;
      ctl.load     = 1'b0;
      ctl.shift    = 1'b0;
      ctl.we       = 1'b0;
      ctl.addr     = cls_ff;
      case (state_ff)
         S_IDLE: begin
            ctl.addr = req_addr;
            ctl.load = go;
            pos_in   = '0;
            if (go) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            case (mode_ff)
               MODE_ADD: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     ctl.we    = 1'b1;
                     pick_left = new_ff.urg;
                     pick_tail = !new_ff.urg;
                     len_we    = 1'b1;
                     len_wr    = len_ff + CNT_W'(1);
                     count_in  = len_wr;
                  end
               end
               MODE_TAKE: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     ctl.we       = 1'b1;
                     pick_right   = 1'b1;
                     len_we       = 1'b1;
                     len_wr       = len_ff - CNT_W'(1);
                     count_in     = len_wr;
                     rsp_entry_in = row_head;
                  end
               end
               default: begin
                  if (empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     status_in    = ST_LISTED;
                     rsp_entry_in = row_head;
                     rsp_pos_in   = pos_ff;
                     last_in      = list_last;
                     if (!list_last) begin
                        ctl.shift = 1'b1;
                        pos_in    = pos_ff + POS_W'(1);
                        state_in  = S_EXEC;
                     end
                  end
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // build the row of slot cells, each fed by its neighbors
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      entry_type left_w, right_w;

      if (k == 0) begin : g_first
         assign left_w = new_ff;
      end else begin : g_mid_l
         assign left_w = cell_data[k-1];
      end
      if (k == QUEUE_DEPTH - 1) begin : g_lastc
         assign right_w = cell_data[k];
      end else begin : g_mid_r
         assign right_w = cell_data[k+1];
      end

      always_comb begin
         if (pick_left) begin
            pick[k] = PICK_LEFT;
         end else if (pick_right) begin
            pick[k] = PICK_RIGHT;
         end else if (pick_tail && (len_ff == CNT_W'(k))) begin
            pick[k] = PICK_NEW;
         end else begin
            pick[k] = PICK_OWN;
         end
      end

      pcbpd_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .pick     (pick[k]),
         .left_in  (left_w),
         .right_in (right_w),
         .new_in   (new_ff),
         .data_out (cell_data[k])
      );
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold class lengths
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            length_ff[c] <= '0;
         end
      end else if (len_we) begin
         length_ff[cls_ff] <= len_wr;
      end
   end

   // latch the accepted request and advance the list position
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (go) begin
         mode_ff    <= req_mode;
         cls_ff     <= req_addr;
         new_ff.id  <= req_entry_id;
         new_ff.urg <= req_urgent;
         len_ff     <= length_ff[req_addr];
      end
   end

   // register the result
   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_pos_ff   <= rsp_pos_in;
      count_ff     <= count_in;
      last_ff      <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_status = status_ff;
   assign rsp_out_id        = rsp_entry_ff.id;
   assign rsp_out_urgent    = rsp_entry_ff.urg;
   assign rsp_out_position  = rsp_pos_ff;
   assign rsp_queue_count   = count_ff;
   assign rsp_last          = last_ff;

endmodule

// ===== hdl/pcbpd_cell.sv =====
`timescale 1ns / 1ps
// One queue slot of the deque: holds that slot for every class and a row register.
// Depends on pcbpd_pkg.
module pcbpd_cell (
   input  logic                     clock,
   input  pcbpd_pkg::cell_ctl_type  ctl,
   input  pcbpd_pkg::pick_type      pick,
   input  pcbpd_pkg::entry_type     left_in,
   input  pcbpd_pkg::entry_type     right_in,
   input  pcbpd_pkg::entry_type     new_in,
   output pcbpd_pkg::entry_type     data_out
);
   import pcbpd_pkg::*;

   entry_type slot_mem [NUM_CLASSES];
   entry_type data_ff;
   entry_type wr_in;

   // select the value written back for this slot
   always_comb begin
      case (pick)
         PICK_LEFT:  wr_in = left_in;
         PICK_RIGHT: wr_in = right_in;
         PICK_NEW:   wr_in = new_in;
         default:    wr_in = data_ff;
      endcase
   end

   // write the slot memory
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         slot_mem[ctl.addr] <= wr_in;
      end
   end

   // load the row register from memory, or advance it from the right neighbor
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         data_ff <= slot_mem[ctl.addr];
      end else if (ctl.shift) begin
         data_ff <= right_in;
      end
   end

   assign data_out = data_ff;

endmodule
